### hdl/coarse_sliding_min_max_assert.svh
// Assertion macros used by the top-level RTL file.
`ifndef COARSE_SLIDING_MIN_MAX_ASSERT_SVH
`define COARSE_SLIDING_MIN_MAX_ASSERT_SVH

// Check cons in the same cycle as ante.
`define CSMM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define CSMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/csmm_pkg.sv
`timescale 1ns / 1ps
package csmm_pkg;

  localparam int MAX_LAYERS_DEF   = 10;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam int LC_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_MAX   = 1'd1;

  localparam logic [LC_W-1:0] LAYER_COUNT_RST = 4'd10;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FILL   = 1'b1;

  typedef struct packed {
    logic step;
    logic fill;
    logic track_max;
  } csmm_ctrl_t;

endpackage

### hdl/csmm_cell.sv
`timescale 1ns / 1ps
module csmm_cell #(
  parameter int SAMPLE_WIDTH = csmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  csmm_pkg::csmm_ctrl_t           ctrl,
  input  logic                           link_in,
  input  logic                           cnt_bit,
  input  logic                           in_range,
  input  logic signed [SAMPLE_WIDTH-1:0] data_in,
  input  logic signed [SAMPLE_WIDTH-1:0] fill_val,
  output logic                           en_out,
  output logic signed [SAMPLE_WIDTH-1:0] pick_out,
  output logic signed [SAMPLE_WIDTH-1:0] nxt_cur,
  output logic signed [SAMPLE_WIDTH-1:0] nxt_prev
);
  import csmm_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] cur_r, cur_nxt;
  logic signed [SAMPLE_WIDTH-1:0] prev_r, prev_nxt;
  logic                           en;

  assign en     = link_in & cnt_bit & in_range;
  assign en_out = en;

  always_comb begin
    if (ctrl.track_max) begin
      pick_out = (cur_r > prev_r) ? cur_r : prev_r;
    end else begin
      pick_out = (cur_r < prev_r) ? cur_r : prev_r;
    end
  end

  // shift the pair when this layer is reached by the trailing-ones run
  assign nxt_cur  = en ? data_in : cur_r;
  assign nxt_prev = en ? cur_r : prev_r;

  always_comb begin
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    if (ctrl.fill) begin
      cur_nxt  = fill_val;
      prev_nxt = fill_val;
    end else if (ctrl.step) begin
      cur_nxt  = nxt_cur;
      prev_nxt = nxt_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      prev_r <= '0;
    end else begin
      cur_r  <= cur_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

### hdl/coarse_sliding_min_max.sv
`timescale 1ns / 1ps
// Channel   Direction  Ports                                   Moves
// in        input      in_valid/in_ready, in_command, in_value  one sample or fill request
// out       output     out_valid/out_ready, out_extreme         one result per sample
// cfg       input      cfg_we, cfg_index, cfg_wdata             register write, no wait
//
// The whole row of layer cells updates at the edge that accepts a request.
// A sample's result is registered at that edge and shows on out_* in the next cycle.
// A new request is taken in the same cycle as the waiting result is taken.
// Reset (rst_n low at a clock edge) clears all layers, the run counter and the output valid flag.
// A stalled output holds its result and blocks further requests; fills give no result.
module coarse_sliding_min_max #(
  parameter int MAX_LAYERS   = csmm_pkg::MAX_LAYERS_DEF,
  parameter int SAMPLE_WIDTH = csmm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]       out_extreme,
  input  logic                                 cfg_we,
  input  logic [csmm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [csmm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import csmm_pkg::*;

  localparam int CNT_W = (MAX_LAYERS > 1) ? MAX_LAYERS - 1 : 1;
  localparam int TOP_W = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  logic [LC_W-1:0]                lc_r;
  logic                           tmax_r;
  logic [CNT_W-1:0]               cnt_r, cnt_nxt, cnt_inc;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_extreme_r, extreme_nxt;

  logic [TOP_W-1:0]               top;
  logic [CNT_W:0]                 bound;
  logic                           accept, step, fill;
  csmm_ctrl_t                     ctrl;

  logic [MAX_LAYERS-1:0]          en_w;
  logic [MAX_LAYERS:0]            en_plus;
  logic signed [SAMPLE_WIDTH-1:0] pick_w     [MAX_LAYERS];
  logic signed [SAMPLE_WIDTH-1:0] nxt_cur_w  [MAX_LAYERS];
  logic signed [SAMPLE_WIDTH-1:0] nxt_prev_w [MAX_LAYERS];
  logic signed [SAMPLE_WIDTH-1:0] top_cur, top_prev;

  assign in_ready    = !out_valid_r || out_ready;
  assign accept      = in_valid && in_ready;
  assign step        = accept && (in_command == CMD_SAMPLE);
  assign fill        = accept && (in_command == CMD_FILL);
  assign out_valid   = out_valid_r;
  assign out_extreme = out_extreme_r;

  assign ctrl.step      = step;
  assign ctrl.fill      = fill;
  assign ctrl.track_max = tmax_r;

  always_comb begin
    if (lc_r == '0) begin
      top = '0;
    end else if (int'(lc_r) > MAX_LAYERS) begin
      top = TOP_W'(MAX_LAYERS - 1);
    end else begin
      top = TOP_W'(lc_r - 4'd1);
    end
  end

  for (genvar i = 0; i < MAX_LAYERS; i++) begin : g_cell
    logic                           link_in, cnt_bit, in_range;
    logic signed [SAMPLE_WIDTH-1:0] data_in;
    if (i == 0) begin : g_first
      assign link_in = 1'b1;
      assign cnt_bit = 1'b1;
      assign data_in = in_value;
    end else begin : g_rest
      assign link_in = en_w[i-1];
      assign cnt_bit = cnt_r[i-1];
      assign data_in = pick_w[i-1];
    end
    assign in_range = (TOP_W'(i) <= top);

    csmm_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .link_in  (link_in),
      .cnt_bit  (cnt_bit),
      .in_range (in_range),
      .data_in  (data_in),
      .fill_val (in_value),
      .en_out   (en_w[i]),
      .pick_out (pick_w[i]),
      .nxt_cur  (nxt_cur_w[i]),
      .nxt_prev (nxt_prev_w[i])
    );
  end

  assign top_cur  = nxt_cur_w[top];
  assign top_prev = nxt_prev_w[top];

  always_comb begin
    if (tmax_r) begin
      extreme_nxt = (top_cur > top_prev) ? top_cur : top_prev;
    end else begin
      extreme_nxt = (top_cur < top_prev) ? top_cur : top_prev;
    end
  end

  assign cnt_inc = cnt_r + 1'b1;
  assign bound   = (CNT_W + 1)'(1) << top;

  always_comb begin
    cnt_nxt = cnt_r;
    if (step) begin
      cnt_nxt = ({1'b0, cnt_inc} >= bound) ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r   <= LAYER_COUNT_RST;
      tmax_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LAYER_COUNT: begin
          lc_r <= cfg_wdata[LC_W-1:0];
        end
        REG_TRACK_MAX: begin
          tmax_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_extreme_r <= extreme_nxt;
    end
  end

  assign en_plus = {1'b0, en_w} + 1'b1;

`include "coarse_sliding_min_max_assert.svh"

  `CSMM_ASSERT_SAME(a_en_prefix, 1'b1, $onehot(en_plus), "layer enables not a prefix")
  `CSMM_ASSERT_NEXT(a_cnt_bound, step, {1'b0, cnt_r} < $past(bound), "run counter past wrap")
  `CSMM_ASSERT_NEXT(a_fill_cnt, fill, cnt_r == $past(cnt_r), "fill moved run counter")
  `CSMM_ASSERT_NEXT(a_step_result, step, out_valid_r, "sample gave no result")

endmodule
